FILE: rtl/core/lwwp_pkg.sv
package lwwp_pkg;

	localparam int LWWP_TABLE_DEPTH = 256;

	localparam int CMD_W   = 1;
	localparam int SLOT_W  = 8;
	localparam int KIND_W  = 15;
	localparam int LEVEL_W = 8;
	localparam int TOTAL_W = 15;
	localparam int RND_W   = 16;
	localparam int CFG_W   = 9;

	localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
	localparam logic [CMD_W-1:0] CMD_PICK = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [LEVEL_W-1:0] level;
		logic [TOTAL_W-1:0] total;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_RD_LAST,
		OP_CLAMP,
		OP_SCAN1,
		OP_CHECK,
		OP_DIV,
		OP_S2_INIT,
		OP_SCAN2
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   push;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic none;
		logic weight_pos;
		logic div_done;
		logic span_empty;
	} dp_status_t;

endpackage

FILE: rtl/core/lwwp_if.sv
interface lwwp_in_if
	import lwwp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [SLOT_W-1:0]  slot;
	logic [KIND_W-1:0]  entry_kind;
	logic [LEVEL_W-1:0] entry_level;
	logic [TOTAL_W-1:0] entry_total;
	logic [LEVEL_W-1:0] pick_level;
	logic [LEVEL_W-1:0] pick_level_min;
	logic [RND_W-1:0]   random_value;

	modport source (
		output valid, command, slot, entry_kind, entry_level, entry_total,
		       pick_level, pick_level_min, random_value,
		input  ready
	);
	modport sink (
		input  valid, command, slot, entry_kind, entry_level, entry_total,
		       pick_level, pick_level_min, random_value,
		output ready
	);
endinterface

interface lwwp_out_if
	import lwwp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              found;
	logic [KIND_W-1:0] chosen_kind;

	modport source (
		output valid, found, chosen_kind,
		input  ready
	);
	modport sink (
		input  valid, found, chosen_kind,
		output ready
	);
endinterface

FILE: rtl/core/lwwp_ram.sv
module lwwp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/lwwp_div.sv
module lwwp_div
	import lwwp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RND_W-1:0]   dividend,
	input  logic [TOTAL_W-1:0] divisor,
	output logic               done,
	output logic [TOTAL_W-1:0] rem
);
	localparam int CNT_W = $clog2(RND_W + 1);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [RND_W-1:0]   num_q;
	logic [TOTAL_W-1:0] den_q;
	logic [TOTAL_W-1:0] rem_q;
	logic               done_q;
	logic [TOTAL_W:0]   trial;
	logic [TOTAL_W:0]   diff;

	// remainder stays below the divisor, so the shifted trial fits one extra bit
	assign trial = {rem_q, num_q[RND_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[RND_W-2:0], 1'b0};
			if (!diff[TOTAL_W]) begin
				rem_q <= diff[TOTAL_W-1:0];
			end else begin
				rem_q <= trial[TOTAL_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

FILE: rtl/core/lwwp_dp.sv
module lwwp_dp
	import lwwp_pkg::*;
#(
	parameter int TABLE_DEPTH = LWWP_TABLE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         st,
	input  logic               cfg_wr_en,
	input  logic [CFG_W-1:0]   cfg_wr_data,
	input  logic [CMD_W-1:0]   command,
	input  logic [SLOT_W-1:0]  slot,
	input  logic [KIND_W-1:0]  entry_kind,
	input  logic [LEVEL_W-1:0] entry_level,
	input  logic [TOTAL_W-1:0] entry_total,
	input  logic [LEVEL_W-1:0] pick_level,
	input  logic [LEVEL_W-1:0] pick_level_min,
	input  logic [RND_W-1:0]   random_value,
	output logic               found,
	output logic [KIND_W-1:0]  chosen_kind
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int SW = $clog2(TABLE_DEPTH + 1);

	logic [CFG_W-1:0]   cfg_q;
	logic [SW-1:0]      size_q;
	logic [IW-1:0]      last_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [LEVEL_W-1:0] min_lvl_q;
	logic [RND_W-1:0]   rnd_q;
	logic [SW-1:0]      rd_idx_q;
	logic               v_s1;
	logic [IW-1:0]      idx_s1;
	logic [SW-1:0]      min_idx_q;
	logic [TOTAL_W-1:0] min_total_q;
	logic [IW-1:0]      max_idx_q;
	logic [TOTAL_W-1:0] max_total_q;
	logic               max_valid_q;
	logic [TOTAL_W-1:0] choice_q;
	logic [RND_W-1:0]   target_q;
	logic               found_q;
	logic [KIND_W-1:0]  kind_q;
	logic               out_found_q;
	logic [KIND_W-1:0]  out_kind_q;

	logic [SW-1:0]      size_next;
	logic               ram_we;
	logic [IW-1:0]      raddr;
	logic [ENTRY_W-1:0] rdata;
	entry_t             ent;
	entry_t             wr_ent;
	logic               scanning;
	logic               issue;
	logic               brk;
	logic               hit;
	logic [TOTAL_W:0]   weight;
	logic               div_start;
	logic               div_done;
	logic [TOTAL_W-1:0] div_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(1);
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (cfg_q == '0) begin
			size_next = SW'(1);
		end else if (32'(cfg_q) > TABLE_DEPTH) begin
			size_next = SW'(TABLE_DEPTH);
		end else begin
			size_next = SW'(cfg_q);
		end
	end

	assign ram_we = (cmd.op == OP_CAPTURE) && (command == CMD_LOAD)
		&& (32'(slot) < TABLE_DEPTH);
	assign wr_ent = '{kind: entry_kind, level: entry_level, total: entry_total};
	assign raddr  = (cmd.op == OP_RD_LAST) ? last_q : rd_idx_q[IW-1:0];
	assign ent    = entry_t'(rdata);

	lwwp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(IW'(slot)),
		.wdata(wr_ent),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign scanning = (cmd.op == OP_SCAN1) || (cmd.op == OP_SCAN2);
	always_comb begin
		if (cmd.op == OP_SCAN1) begin
			issue = rd_idx_q < size_q;
		end else if (cmd.op == OP_SCAN2) begin
			issue = rd_idx_q <= SW'(max_idx_q);
		end else begin
			issue = 1'b0;
		end
	end

	assign brk = ent.level > lvl_q;
	assign hit = {1'b0, ent.total} > target_q;

	assign weight    = {1'b0, max_total_q} - {1'b0, min_total_q};
	assign div_start = (cmd.op == OP_CHECK) && !st.none && st.weight_pos;

	lwwp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(rnd_q),
		.divisor (weight[TOTAL_W-1:0]),
		.done    (div_done),
		.rem     (div_rem)
	);

	always_comb begin
		st            = '0;
		st.none       = !max_valid_q || (max_total_q == '0);
		st.weight_pos = !weight[TOTAL_W] && (weight != '0);
		st.div_done   = div_done;
		st.span_empty = min_idx_q > SW'(max_idx_q);
		if (cmd.op == OP_SCAN1) begin
			st.scan_done = v_s1 && (brk || (idx_s1 == last_q));
		end else if (cmd.op == OP_SCAN2) begin
			st.scan_done = v_s1 && (hit || (idx_s1 == max_idx_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= scanning && issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IW-1:0];
		if (issue) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
		case (cmd.op)
			OP_CAPTURE: begin
				size_q   <= size_next;
				last_q   <= IW'(size_next - SW'(1));
				lvl_q    <= pick_level;
				min_lvl_q <= (pick_level_min > pick_level) ? pick_level : pick_level_min;
				rnd_q    <= random_value;
				found_q  <= 1'b0;
				kind_q   <= '0;
			end
			OP_CLAMP: begin
				if (min_lvl_q > ent.level) begin
					min_lvl_q <= ent.level;
				end
				rd_idx_q    <= '0;
				min_idx_q   <= '0;
				min_total_q <= '0;
				max_idx_q   <= '0;
				max_total_q <= '0;
				max_valid_q <= 1'b0;
			end
			OP_SCAN1: begin
				if (v_s1) begin
					if (ent.level < min_lvl_q) begin
						min_idx_q   <= SW'(idx_s1) + 1'b1;
						min_total_q <= ent.total;
					end
					if (!brk) begin
						max_idx_q   <= idx_s1;
						max_total_q <= ent.total;
						max_valid_q <= 1'b1;
					end
				end
			end
			OP_CHECK: begin
				choice_q <= '0;
			end
			OP_DIV: begin
				if (div_done) begin
					choice_q <= div_rem;
				end
			end
			OP_S2_INIT: begin
				rd_idx_q <= min_idx_q;
				target_q <= {1'b0, choice_q} + {1'b0, min_total_q};
			end
			OP_SCAN2: begin
				if (v_s1 && hit) begin
					found_q <= 1'b1;
					kind_q  <= ent.kind;
				end
			end
			default: begin
			end
		endcase
		if (cmd.push) begin
			out_found_q <= found_q;
			out_kind_q  <= kind_q;
		end
	end

	assign found       = out_found_q;
	assign chosen_kind = out_kind_q;
endmodule

FILE: rtl/core/lwwp_ctrl.sv
module lwwp_ctrl
	import lwwp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [CMD_W-1:0] command,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output dp_cmd_t          cmd,
	input  dp_status_t       st
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_LAST,
		S_CLAMP,
		S_SCAN1,
		S_CHECK,
		S_DIV,
		S_S2_INIT,
		S_SCAN2,
		S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   push;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign push      = (state_q == S_RESP) && (!out_valid_q || rsp_ready);

	always_comb begin
		cmd.push = push;
		case (state_q)
			S_IDLE:    cmd.op = req_valid ? OP_CAPTURE : OP_NONE;
			S_RD_LAST: cmd.op = OP_RD_LAST;
			S_CLAMP:   cmd.op = OP_CLAMP;
			S_SCAN1:   cmd.op = OP_SCAN1;
			S_CHECK:   cmd.op = OP_CHECK;
			S_DIV:     cmd.op = OP_DIV;
			S_S2_INIT: cmd.op = OP_S2_INIT;
			S_SCAN2:   cmd.op = OP_SCAN2;
			default:   cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= (command == CMD_PICK) ? S_RD_LAST : S_RESP;
					end
				end
				S_RD_LAST: state_q <= S_CLAMP;
				S_CLAMP:   state_q <= S_SCAN1;
				S_SCAN1: begin
					if (st.scan_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (st.none) begin
						state_q <= S_RESP;
					end else if (st.weight_pos) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_S2_INIT;
					end
				end
				S_DIV: begin
					if (st.div_done) begin
						state_q <= S_S2_INIT;
					end
				end
				S_S2_INIT: state_q <= st.span_empty ? S_RESP : S_SCAN2;
				S_SCAN2: begin
					if (st.scan_done) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (push) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/core/level_window_weighted_pick.sv
// Channel  Dir  Beat contents
// -------  ---  ---------------------------------------------------------------
// req      in   command, slot, entry_kind/level/total, pick_level(_min), random
// rsp      out  found, chosen_kind
// cfg      in   cfg_wr_en / cfg_wr_data: entries_in_use, no read-back
//
// A load goes from accept straight to the result state. A pick makes one pass over
// the entries in use in the table RAM to find the level window, a 16-step
// remainder unit reduces the random word, and a second pass picks the entry.
// One item is in flight at a time; the next is taken while the result waits.
// Reset clears the controller and sets entries_in_use to 1; table contents are
// undefined until loaded. A stalled result holds the block before its next result.
module level_window_weighted_pick
	import lwwp_pkg::*;
#(
	parameter int TABLE_DEPTH = LWWP_TABLE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	lwwp_in_if.sink          req,
	lwwp_out_if.source       rsp,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data
);
	dp_cmd_t    cmd;
	dp_status_t st;

	lwwp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.command  (req.command),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.cmd      (cmd),
		.st       (st)
	);

	lwwp_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.command       (req.command),
		.slot          (req.slot),
		.entry_kind    (req.entry_kind),
		.entry_level   (req.entry_level),
		.entry_total   (req.entry_total),
		.pick_level    (req.pick_level),
		.pick_level_min(req.pick_level_min),
		.random_value  (req.random_value),
		.found         (rsp.found),
		.chosen_kind   (rsp.chosen_kind)
	);
endmodule

FILE: rtl/core/lwwp_chk.sv
module lwwp_chk
	import lwwp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic              rsp_found,
	input logic [KIND_W-1:0] rsp_chosen_kind
);
	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
			&& $stable(rsp_chosen_kind))
		else $error("result beat changed while stalled");

	// one item in flight: ready drops right after an accepted beat
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second beat taken while an item is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_chosen_kind == '0)
		else $error("kind not zero on a miss");

	// a fresh result coincides with the return to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> req_ready)
		else $error("result raised while still busy");
endmodule

bind level_window_weighted_pick lwwp_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_found      (rsp.found),
	.rsp_chosen_kind(rsp.chosen_kind)
);

FILE: bench/tb_level_window_weighted_pick.sv
module tb_level_window_weighted_pick;
	timeunit 1ns;
	timeprecision 1ps;

	import lwwp_pkg::*;

	localparam int RANDOM_ITEMS = 1000;
	localparam int CALM_FROM    = 850;
	localparam int TAIL_CYCLES  = 600;
	localparam int CYCLE_LIMIT  = 2_000_000;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [SLOT_W-1:0]  slot;
		logic [KIND_W-1:0]  entry_kind;
		logic [LEVEL_W-1:0] entry_level;
		logic [TOTAL_W-1:0] entry_total;
		logic [LEVEL_W-1:0] pick_level;
		logic [LEVEL_W-1:0] pick_level_min;
		logic [RND_W-1:0]   random_value;
	} req_beat_t;

	typedef struct packed {
		logic              found;
		logic [KIND_W-1:0] kind;
	} answer_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	lwwp_in_if  req_ch();
	lwwp_out_if rsp_ch();

	level_window_weighted_pick uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	entry_t           shadow_table [LWWP_TABLE_DEPTH];
	logic [CFG_W-1:0] in_use_reg;
	answer_t          pending_answers [$];
	int               mismatches;
	int               random_items;
	int               cycles;
	bit               calm;
	int               stall_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side: ready drops for random stretches unless calm
	initial begin
		rsp_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int effective_size();
		if (in_use_reg == 0)
			return 1;
		if (in_use_reg > LWWP_TABLE_DEPTH)
			return LWWP_TABLE_DEPTH;
		return int'(in_use_reg);
	endfunction

	function automatic answer_t predict_pick(input logic [LEVEL_W-1:0] top_lvl,
			input logic [LEVEL_W-1:0] low_lvl, input logic [RND_W-1:0] rnd);
		answer_t            ans;
		int                 n, lo_idx, hi_idx, lo_sum, hi_sum, span, offs;
		logic [LEVEL_W-1:0] floor_lvl;
		ans = '0;
		n = effective_size();
		floor_lvl = (low_lvl > top_lvl) ? top_lvl : low_lvl;
		if (floor_lvl > shadow_table[n-1].level)
			floor_lvl = shadow_table[n-1].level;
		lo_idx = 0;
		hi_idx = -1;
		lo_sum = 0;
		hi_sum = 0;
		for (int i = 0; i < n; i++) begin
			if (shadow_table[i].level < floor_lvl) begin
				lo_idx = i + 1;
				lo_sum = int'(shadow_table[i].total);
			end
			if (shadow_table[i].level > top_lvl)
				break;
			hi_sum = int'(shadow_table[i].total);
			hi_idx = i;
		end
		if (hi_sum == 0 || hi_idx < 0)
			return ans;
		span = hi_sum - lo_sum;
		// unsorted table: a non-positive span weight gives offset 0
		offs = (span > 0) ? int'(rnd) % span : 0;
		for (int i = lo_idx; i <= hi_idx; i++) begin
			if (offs + lo_sum < int'(shadow_table[i].total)) begin
				ans.found = 1'b1;
				ans.kind  = shadow_table[i].kind;
				return ans;
			end
		end
		return ans;
	endfunction

	function automatic req_beat_t random_beat();
		req_beat_t b;
		b.command        = CMD_W'($urandom_range(0, 1));
		b.slot           = SLOT_W'($urandom_range(0, 255));
		b.entry_kind     = KIND_W'($urandom_range(0, 32767));
		b.entry_level    = LEVEL_W'($urandom_range(0, 255));
		b.entry_total    = TOTAL_W'($urandom_range(0, 32767));
		b.pick_level     = LEVEL_W'($urandom_range(0, 255));
		b.pick_level_min = LEVEL_W'($urandom_range(0, 255));
		b.random_value   = RND_W'($urandom_range(0, 65535));
		return b;
	endfunction

	task automatic send_item(input req_beat_t b);
		int      gap;
		answer_t ans;
		if (random_items >= CALM_FROM)
			calm = 1'b1;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.command        <= b.command;
		req_ch.slot           <= b.slot;
		req_ch.entry_kind     <= b.entry_kind;
		req_ch.entry_level    <= b.entry_level;
		req_ch.entry_total    <= b.entry_total;
		req_ch.pick_level     <= b.pick_level;
		req_ch.pick_level_min <= b.pick_level_min;
		req_ch.random_value   <= b.random_value;
		req_ch.valid          <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		// beat taken: update the shadow table in acceptance order
		ans = '0;
		if (b.command == CMD_LOAD) begin
			if (b.slot < LWWP_TABLE_DEPTH)
				shadow_table[b.slot] = '{kind: b.entry_kind, level: b.entry_level,
					total: b.entry_total};
		end else begin
			ans = predict_pick(b.pick_level, b.pick_level_min, b.random_value);
		end
		pending_answers.push_back(ans);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_in_use(input logic [CFG_W-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		in_use_reg = v;
	endtask

	task automatic load_entry(input int s, input int k, input int lvl, input int tot);
		req_beat_t b;
		b = random_beat();
		b.command     = CMD_LOAD;
		b.slot        = SLOT_W'(s);
		b.entry_kind  = KIND_W'(k);
		b.entry_level = LEVEL_W'(lvl);
		b.entry_total = TOTAL_W'(tot);
		send_item(b);
	endtask

	task automatic pick(input int lvl, input int lvl_min, input int rnd);
		req_beat_t b;
		b = random_beat();
		b.command        = CMD_PICK;
		b.pick_level     = LEVEL_W'(lvl);
		b.pick_level_min = LEVEL_W'(lvl_min);
		b.random_value   = RND_W'(rnd);
		send_item(b);
	endtask

	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: found=%0b kind=%0d",
						rsp_ch.found, rsp_ch.chosen_kind);
			end else begin
				want = pending_answers.pop_front();
				if (rsp_ch.found !== want.found || rsp_ch.chosen_kind !== want.kind) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected found=%0b kind=%0d, got found=%0b kind=%0d",
							want.found, want.kind, rsp_ch.found, rsp_ch.chosen_kind);
				end
			end
		end
	end

	// Reset value of one entry in use; single-entry extremes
	task automatic test_single_entry();
		load_entry(0, 32767, 0, 32767);
		pick(0, 0, 65535);
		pick(255, 255, 0);
	endtask

	// Empty window, zero-weight entry, clamped minimum, full-range random words
	task automatic test_window_cases();
		write_in_use(4);
		load_entry(0, 11, 5, 10);
		load_entry(1, 22, 10, 10);
		load_entry(2, 33, 10, 40);
		load_entry(3, 44, 200, 100);
		pick(4, 0, 123);
		pick(255, 0, 99);
		pick(10, 10, 0);
		pick(10, 200, 65535);
		pick(199, 6, 29);
	endtask

	// Zero top total, then an unsorted table, picked with and without a match
	task automatic test_unsorted_and_zero();
		write_in_use(2);
		load_entry(0, 5, 0, 0);
		load_entry(1, 6, 50, 0);
		pick(60, 0, 4321);
		load_entry(0, 7, 0, 500);
		load_entry(1, 8, 9, 100);
		pick(9, 9, 1234);
		pick(9, 0, 77);
	endtask

	// Zero entries in use behaves as one
	task automatic test_in_use_floor();
		write_in_use(0);
		pick(0, 0, 321);
	endtask

	task automatic fill_table(input int n, input bit sorted, output int lvl_lo,
			output int lvl_hi);
		req_beat_t b;
		int        lvl, sum, step;
		lvl = $urandom_range(0, 200);
		sum = 0;
		step = 32767 / n;
		lvl_lo = sorted ? lvl : 0;
		for (int s = 0; s < n; s++) begin
			b = random_beat();
			b.command = CMD_LOAD;
			b.slot    = SLOT_W'(s);
			if (sorted) begin
				if ($urandom_range(0, 5) != 0)
					sum += $urandom_range(1, step);
				b.entry_level = LEVEL_W'(lvl);
				b.entry_total = TOTAL_W'(sum);
				lvl += ($urandom_range(0, 7) == 0) ? $urandom_range(4, 30)
					: $urandom_range(0, 2);
				if (lvl > 255)
					lvl = 255;
			end
			send_item(b);
			random_items++;
		end
		lvl_hi = sorted ? lvl : 255;
	endtask

	task automatic test_random_tables();
		req_beat_t        b;
		int               phase, n, picks, lvl_lo, lvl_hi, r;
		logic [CFG_W-1:0] cfg_val;
		bit               reload;
		phase = 0;
		lvl_lo = 0;
		lvl_hi = 255;
		while (random_items < RANDOM_ITEMS) begin
			if (random_items >= CALM_FROM)
				calm = 1'b1;
			reload = 1'b1;
			r = $urandom_range(0, 19);
			if (phase == 0)
				cfg_val = 511;
			else if (phase == 1) begin
				// reuse the full table from the first phase
				cfg_val = 256;
				reload = 1'b0;
			end else if (r == 0)
				cfg_val = 0;
			else if (r == 1)
				cfg_val = CFG_W'($urandom_range(256, 511));
			else if (r <= 4)
				cfg_val = CFG_W'($urandom_range(17, 64));
			else
				cfg_val = CFG_W'($urandom_range(1, 16));
			write_in_use(cfg_val);
			n = effective_size();
			if (reload)
				fill_table(n, $urandom_range(0, 4) != 0, lvl_lo, lvl_hi);
			picks = (n > 64) ? 12 : $urandom_range(10, 40);
			repeat (picks) begin
				if (random_items >= RANDOM_ITEMS)
					break;
				b = random_beat();
				if ($urandom_range(0, 9) == 0) begin
					// noise: overwrite an entry in use, which may break the order
					b.command = CMD_LOAD;
					b.slot    = SLOT_W'($urandom_range(0, n - 1));
				end else begin
					b.command = CMD_PICK;
					if ($urandom_range(0, 9) < 7)
						b.pick_level = LEVEL_W'($urandom_range(lvl_lo, lvl_hi));
					if ($urandom_range(0, 9) < 6)
						b.pick_level_min = LEVEL_W'($urandom_range(0, b.pick_level));
				end
				send_item(b);
				random_items++;
			end
			phase++;
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		cfg_wr_en             = 1'b0;
		cfg_wr_data           = '0;
		req_ch.valid          = 1'b0;
		req_ch.command        = CMD_LOAD;
		req_ch.slot           = '0;
		req_ch.entry_kind     = '0;
		req_ch.entry_level    = '0;
		req_ch.entry_total    = '0;
		req_ch.pick_level     = '0;
		req_ch.pick_level_min = '0;
		req_ch.random_value   = '0;
		in_use_reg            = 1;
		mismatches            = 0;
		random_items          = 0;
		calm                  = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_single_entry();
		test_window_cases();
		test_unsorted_and_zero();
		test_in_use_floor();
		test_random_tables();

		wait_drained();
		// hold a while longer to catch stray results
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_answers.size() != 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0d results never arrived", pending_answers.size());
		end
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/lwwp_pkg.sv
rtl/core/lwwp_if.sv
rtl/core/lwwp_ram.sv
rtl/core/lwwp_div.sv
rtl/core/lwwp_dp.sv
rtl/core/lwwp_ctrl.sv
rtl/core/level_window_weighted_pick.sv
rtl/core/lwwp_chk.sv
bench/tb_level_window_weighted_pick.sv
